// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define BSMM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define BSMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/bsmm_pkg.sv
package bsmm_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int VAL_W       = 32;
    localparam int CFG_W       = 11;
    localparam int LIM_W       = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    typedef logic [VAL_W-1:0] t_word;

    typedef struct packed {
        logic load;   // latch a new value and start the walk
        logic scan;   // compare one stored entry, shift it up if greater
        logic place;  // write the value and update the spans
        logic emit;   // load the result register
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic greater;
        logic last;
        logic out_free;
    } t_status;

endpackage

// File: hw/rtl/bsmm_if.sv
interface bsmm_in_if;
    logic                           valid;
    logic                           ready;
    logic signed [bsmm_pkg::VAL_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface bsmm_out_if;
    logic                         valid;
    logic                         ready;
    logic                         accepted;
    logic [bsmm_pkg::CFG_W-1:0]   stored_count;
    logic                         spans_valid;
    logic [bsmm_pkg::VAL_W-1:0]   shortest_span;
    logic [bsmm_pkg::VAL_W-1:0]   longest_span;

    modport source (output valid, output accepted, output stored_count, output spans_valid,
                    output shortest_span, output longest_span, input ready);
    modport sink   (input valid, input accepted, input stored_count, input spans_valid,
                    input shortest_span, input longest_span, output ready);
endinterface

// File: hw/rtl/bsmm_controller.sv
module bsmm_controller (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  bsmm_pkg::t_status i_status,
    output bsmm_pkg::t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PLACE,
        ST_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_state     = r_state;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_status.full) begin
                        n_state = ST_EMIT;
                    end else if (i_status.empty) begin
                        n_state = ST_PLACE;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                // stop at the first entry not above the value, or at the bottom
                if (!i_status.greater || i_status.last) begin
                    n_state = ST_PLACE;
                end
            end
            ST_PLACE: begin
                o_cmd.place = 1'b1;
                n_state     = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: hw/rtl/bsmm_datapath.sv
module bsmm_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [bsmm_pkg::CFG_W-1:0]   i_cfg_wr_data,
    input  logic [bsmm_pkg::VAL_W-1:0]   i_value,
    input  bsmm_pkg::t_cmd               i_cmd,
    output bsmm_pkg::t_status            o_status,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic                         o_accepted,
    output logic [bsmm_pkg::CFG_W-1:0]   o_stored_count,
    output logic                         o_spans_valid,
    output logic [bsmm_pkg::VAL_W-1:0]   o_shortest_span,
    output logic [bsmm_pkg::VAL_W-1:0]   o_longest_span
);

    localparam int ADDR_W = bsmm_pkg::ADDR_W;
    localparam int CNT_W  = bsmm_pkg::CNT_W;
    localparam int VAL_W  = bsmm_pkg::VAL_W;
    localparam int CFG_W  = bsmm_pkg::CFG_W;
    localparam int LIM_W  = bsmm_pkg::LIM_W;

    // Values are held with the sign bit inverted so unsigned compares order them.
    bsmm_pkg::t_word r_mem [bsmm_pkg::MAX_ENTRIES];

    logic [CFG_W-1:0]   r_capacity;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_pos;
    bsmm_pkg::t_word    r_v;
    bsmm_pkg::t_word    r_rd_data;
    bsmm_pkg::t_word    r_gap_lo;
    bsmm_pkg::t_word    r_gap_hi;
    logic               r_has_lo;
    logic               r_has_hi;
    logic               r_acc;
    bsmm_pkg::t_word    r_min_gap;
    bsmm_pkg::t_word    r_smallest;
    bsmm_pkg::t_word    r_largest;

    logic               r_out_valid;
    logic               r_out_acc;
    logic [CFG_W-1:0]   r_out_count;
    logic               r_out_spans;
    bsmm_pkg::t_word    r_out_short;
    bsmm_pkg::t_word    r_out_long;

    logic [LIM_W-1:0]   cap_ext;
    logic [LIM_W-1:0]   max_ext;
    logic [LIM_W-1:0]   limit;
    logic               full;
    logic               greater;
    bsmm_pkg::t_word    v_flip;
    logic [CNT_W-1:0]   rd_idx;
    logic               wr_en;
    bsmm_pkg::t_word    wr_data;
    bsmm_pkg::t_word    cand_lo;
    bsmm_pkg::t_word    cand_hi;
    bsmm_pkg::t_word    cand_min;
    bsmm_pkg::t_word    n_min_gap;
    logic               spans_ok;

    assign cap_ext = LIM_W'(r_capacity);
    assign max_ext = LIM_W'(bsmm_pkg::MAX_ENTRIES);
    assign limit   = (cap_ext > max_ext) ? max_ext : cap_ext;
    assign full    = LIM_W'(r_count) >= limit;
    assign greater = r_rd_data > r_v;
    assign v_flip  = {~i_value[VAL_W-1], i_value[VAL_W-2:0]};

    // Read one entry ahead of the walk so each compare finds its data registered.
    assign rd_idx  = i_cmd.load ? (r_count - CNT_W'(1)) : (r_pos - CNT_W'(2));
    assign wr_en   = (i_cmd.scan && greater) || i_cmd.place;
    assign wr_data = i_cmd.place ? r_v : r_rd_data;

    assign cand_lo   = r_has_lo ? r_gap_lo : '1;
    assign cand_hi   = r_has_hi ? r_gap_hi : '1;
    assign cand_min  = (cand_lo < cand_hi) ? cand_lo : cand_hi;
    assign n_min_gap = (cand_min < r_min_gap) ? cand_min : r_min_gap;
    assign spans_ok  = r_count >= CNT_W'(2);

    always_comb begin
        o_status          = '0;
        o_status.full     = full;
        o_status.empty    = (r_count == '0);
        o_status.greater  = greater;
        o_status.last     = (r_pos == CNT_W'(1));
        o_status.out_free = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_pos[ADDR_W-1:0]] <= wr_data;
        end
        r_rd_data <= r_mem[rd_idx[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_v      <= v_flip;
            r_pos    <= r_count;
            r_acc    <= !full;
            r_has_lo <= 1'b0;
            r_has_hi <= 1'b0;
        end
        if (i_cmd.scan) begin
            if (greater) begin
                r_gap_hi <= r_rd_data - r_v;
                r_has_hi <= 1'b1;
                r_pos    <= r_pos - CNT_W'(1);
            end else begin
                r_gap_lo <= r_v - r_rd_data;
                r_has_lo <= 1'b1;
            end
        end
        if (i_cmd.emit) begin
            r_out_acc   <= r_acc;
            r_out_count <= CFG_W'(r_count);
            r_out_spans <= spans_ok;
            r_out_short <= spans_ok ? r_min_gap : '0;
            r_out_long  <= spans_ok ? (r_largest - r_smallest) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= '0;
            r_count     <= '0;
            r_min_gap   <= '1;
            r_smallest  <= '0;
            r_largest   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_capacity <= i_cfg_wr_data;
            end
            if (i_cmd.place) begin
                r_min_gap <= n_min_gap;
                r_count   <= r_count + CNT_W'(1);
                if (r_count == '0) begin
                    r_smallest <= r_v;
                    r_largest  <= r_v;
                end else begin
                    if (r_v < r_smallest) begin
                        r_smallest <= r_v;
                    end
                    if (r_v > r_largest) begin
                        r_largest <= r_v;
                    end
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_accepted      = r_out_acc;
    assign o_stored_count  = r_out_count;
    assign o_spans_valid   = r_out_spans;
    assign o_shortest_span = r_out_short;
    assign o_longest_span  = r_out_long;

endmodule

// File: hw/rtl/bounded_set_min_max_gap_unit.sv
// Bounded sorted set with shortest and longest span. Each input transaction
// inserts a signed value into a sorted store of up to 1024 entries (limited by
// the capacity register; capacity zero rejects everything) and yields one result
// transaction with the accepted flag, the count held and both spans. A rejected
// value goes straight to the result stage; an accepted one walks down past every
// stored entry greater than it, comparing one smaller entry if one is held, and
// is then placed. The insertion walk moves one entry a cycle through the store's
// single read port and single write port. One value is in flight at a time; the
// result register holds a finished result while the next value is taken. The
// store needs no clearing after reset.
module bounded_set_min_max_gap_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [bsmm_pkg::CFG_W-1:0] i_cfg_wr_data,
    bsmm_in_if.sink                    i_value_ch,
    bsmm_out_if.source                 o_result_ch
);

    bsmm_pkg::t_cmd    cmd;
    bsmm_pkg::t_status status;
    logic              in_ready;

    bsmm_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_value_ch.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    bsmm_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_value         (i_value_ch.value),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_out_ready     (o_result_ch.ready),
        .o_out_valid     (o_result_ch.valid),
        .o_accepted      (o_result_ch.accepted),
        .o_stored_count  (o_result_ch.stored_count),
        .o_spans_valid   (o_result_ch.spans_valid),
        .o_shortest_span (o_result_ch.shortest_span),
        .o_longest_span  (o_result_ch.longest_span)
    );

    assign i_value_ch.ready = in_ready;

endmodule

// File: hw/rtl/bsmm_checker.sv
`include "assert_macros.svh"

module bsmm_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic                       i_out_accepted,
    input logic [bsmm_pkg::CFG_W-1:0] i_out_count,
    input logic                       i_out_spans_valid
);

    // A result held back by the sink stays offered with the same flag and count.
    `BSMM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_accepted) && $stable(i_out_count), "result dropped while stalled")

    // One value at a time: no new transaction straight after an accepted one.
    `BSMM_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "input taken while a value is in flight")

    // A fresh result is only raised from the busy phase, never from idle.
    `BSMM_ASSERT_IMPL(a_result_from_busy, i_clk, i_rst_n, $rose(i_out_valid), !$past(i_in_ready), "result raised while idle")

    // Spans are valid exactly when two or more values are held.
    `BSMM_ASSERT_IMPL(a_spans_valid, i_clk, i_rst_n, i_out_valid, i_out_spans_valid == (i_out_count >= bsmm_pkg::CFG_W'(2)), "spans_valid disagrees with count")

endmodule

bind bounded_set_min_max_gap_unit bsmm_checker u_bsmm_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_value_ch.valid),
    .i_in_ready        (i_value_ch.ready),
    .i_out_valid       (o_result_ch.valid),
    .i_out_ready       (o_result_ch.ready),
    .i_out_accepted    (o_result_ch.accepted),
    .i_out_count       (o_result_ch.stored_count),
    .i_out_spans_valid (o_result_ch.spans_valid)
);

// File: tb/tb_bounded_set_min_max_gap_unit.sv
module tb_bounded_set_min_max_gap_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          VAL_W        = bsmm_pkg::VAL_W;
    localparam int          CFG_W        = bsmm_pkg::CFG_W;
    localparam int          MAX_ENTRIES  = bsmm_pkg::MAX_ENTRIES;
    localparam int          RESET_CYCLES = 11;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          MAX_REPORTS  = 10;
    localparam int          WIDE_FILL    = 60;
    localparam int unsigned CYCLE_LIMIT  = 3_000_000;
    localparam logic [VAL_W-1:0] SIGN_FLIP = 32'h8000_0000;
    localparam logic signed [VAL_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic             accepted;
        logic [CFG_W-1:0] stored_count;
        logic             spans_valid;
        logic [VAL_W-1:0] shortest_span;
        logic [VAL_W-1:0] longest_span;
    } t_span_report;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic [CFG_W-1:0] i_cfg_wr_data;

    bsmm_in_if  value_ch ();
    bsmm_out_if result_ch ();

    bounded_set_min_max_gap_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_value_ch    (value_ch),
        .o_result_ch   (result_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow of the block: sort keys are values with bit 31 inverted.
    logic [CFG_W-1:0] capacity_shadow = '0;
    logic [VAL_W-1:0] sorted_keys[$];
    logic [VAL_W-1:0] key_lo   = '0;
    logic [VAL_W-1:0] key_hi   = '0;
    logic [VAL_W-1:0] gap_min  = '1;

    t_span_report expected_reports[$];

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_off_left  = 0;
    int          error_count    = 0;
    int          items_sent     = 0;
    int          items_stored   = 0;
    int          results_seen   = 0;
    int unsigned cycle_count    = 0;

    function automatic t_span_report predict_insert(input logic [VAL_W-1:0] raw);
        logic [VAL_W-1:0] key;
        logic [VAL_W-1:0] gap;
        int unsigned      limit;
        int unsigned      held;
        int unsigned      pos;
        t_span_report     r;
        key   = raw ^ SIGN_FLIP;
        limit = (capacity_shadow > MAX_ENTRIES) ? MAX_ENTRIES : capacity_shadow;
        held  = sorted_keys.size();
        r     = '0;
        if (held < limit) begin
            pos = held;
            while (pos > 0 && sorted_keys[pos-1] > key) pos--;
            if (pos > 0) begin
                gap = key - sorted_keys[pos-1];
                if (gap < gap_min) gap_min = gap;
            end
            if (pos < held) begin
                gap = sorted_keys[pos] - key;
                if (gap < gap_min) gap_min = gap;
            end
            sorted_keys.insert(pos, key);
            if (held == 0) begin
                key_lo = key;
                key_hi = key;
            end else begin
                if (key < key_lo) key_lo = key;
                if (key > key_hi) key_hi = key;
            end
            r.accepted = 1'b1;
        end
        held           = sorted_keys.size();
        r.stored_count = held[CFG_W-1:0];
        r.spans_valid  = (held >= 2);
        if (r.spans_valid) begin
            r.shortest_span = gap_min;
            r.longest_span  = key_hi - key_lo;
        end
        return r;
    endfunction

    // Inputs change on the falling edge; acceptance is seen on the rising edge.
    task automatic send_value(input logic signed [VAL_W-1:0] v);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            value_ch.valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        value_ch.valid <= 1'b1;
        value_ch.value <= v;
        @(posedge i_clk);
        while (!value_ch.ready) @(posedge i_clk);
        expected_reports.insert(expected_reports.size(), predict_insert(v));
        items_sent++;
        if (expected_reports[$].accepted) items_stored++;
        @(negedge i_clk);
    endtask

    task automatic wait_for_results();
        value_ch.valid <= 1'b0;
        while (expected_reports.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_capacity(input int unsigned c);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= c[CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        capacity_shadow = c[CFG_W-1:0];
        @(negedge i_clk);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        logic [VAL_W-1:0] base;
        logic [VAL_W-1:0] offset;
        // Land close to a held value now and then to pull the shortest span down.
        if (sorted_keys.size() == 0 || $urandom_range(99) < 70) return $urandom;
        base   = sorted_keys[$urandom_range(sorted_keys.size() - 1)] ^ SIGN_FLIP;
        offset = $urandom_range(65535) + 1;
        return $urandom_range(1) ? base + offset : base - offset;
    endfunction

    task automatic run_random_phase(input int n_items, input int idle_pct,
                                    input int stall_pct, input int room);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        write_capacity(sorted_keys.size() + room);
        repeat (n_items) send_value(pick_value());
        wait_for_results();
    endtask

    task automatic test_capacity_zero_rejects();
        // Reset leaves capacity at zero.
        send_value(VALUE_MIN);
        send_value(VALUE_MAX);
        wait_for_results();
        write_capacity(0);
        send_value(32'sd0);
        send_value(-32'sd1);
        wait_for_results();
    endtask

    task automatic test_first_values();
        write_capacity(1);
        send_value(32'sd1000);
        send_value(32'sd2000);
        wait_for_results();
        write_capacity(3);
        send_value(32'sd5000);
        send_value(32'sd1500);
        send_value(32'sd7);
        wait_for_results();
        // Capacity below the count: nothing is dropped, everything rejected.
        write_capacity(0);
        send_value(-32'sd5);
        wait_for_results();
    endtask

    task automatic test_random_insertions();
        int idle_mode[4]  = '{0, 87, 0, 15};
        int stall_mode[4] = '{0, 0, 87, 15};
        for (int m = 0; m < 4; m++) run_random_phase(105, idle_mode[m], stall_mode[m], 70);
    endtask

    task automatic test_back_pressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_capacity(sorted_keys.size() + 12);
        hold_off_left = 400;
        repeat (24) send_value(pick_value());
        wait_for_results();
    endtask

    task automatic test_wide_capacity();
        longint cur;
        longint step_cap;
        int     n_fill;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // Capacity beyond the store depth: the limit saturates at the depth.
        write_capacity((1 << CFG_W) - 1);
        // Ascend from the largest held value so each insertion walks no entries.
        cur    = longint'(signed'(key_hi ^ SIGN_FLIP));
        n_fill = WIDE_FILL;
        for (int i = 0; i < n_fill; i++) begin
            step_cap = (longint'(VALUE_MAX) - cur) / (n_fill - i + 1);
            cur += $urandom_range(int'(step_cap[31:0]));
            send_value(cur[VAL_W-1:0]);
        end
        send_value(VALUE_MAX);
        send_value(VALUE_MAX);
        send_value(VALUE_MIN);
        send_value(32'sd0);
        send_value(VALUE_MIN);
        wait_for_results();
    endtask

    task automatic test_rejects_when_full();
        send_idle_pct  = 15;
        recv_stall_pct = 15;
        repeat (30) send_value($urandom);
        wait_for_results();
        run_random_phase(12, 87, 0, 0);
        write_capacity(MAX_ENTRIES);
        repeat (12) send_value($urandom);
        wait_for_results();
        write_capacity(1);
        send_idle_pct  = 0;
        recv_stall_pct = 87;
        repeat (12) send_value($urandom);
        wait_for_results();
    endtask

    initial begin : result_sink
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_left > 0) begin
                hold_off_left--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_span_report want;
        t_span_report got;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            results_seen++;
            got.accepted      = result_ch.accepted;
            got.stored_count  = result_ch.stored_count;
            got.spans_valid   = result_ch.spans_valid;
            got.shortest_span = result_ch.shortest_span;
            got.longest_span  = result_ch.longest_span;
            if (expected_reports.size() == 0) begin
                if (error_count < MAX_REPORTS)
                    $display("[%0t] result transaction with nothing outstanding", $realtime);
                error_count++;
            end else begin
                want = expected_reports.pop_front();
                if (got.accepted !== want.accepted || got.stored_count !== want.stored_count
                    || got.spans_valid !== want.spans_valid
                    || got.shortest_span !== want.shortest_span
                    || got.longest_span !== want.longest_span) begin
                    if (error_count < MAX_REPORTS)
                        $display({"[%0t] result %0d mismatch (exp/act): accepted %0b/%0b ",
                                  "count %0d/%0d valid %0b/%0b shortest %h/%h longest %h/%h"},
                                 $realtime, results_seen, want.accepted, got.accepted,
                                 want.stored_count, got.stored_count,
                                 want.spans_valid, got.spans_valid,
                                 want.shortest_span, got.shortest_span,
                                 want.longest_span, got.longest_span);
                    error_count++;
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = '0;
        value_ch.valid = 1'b0;
        value_ch.value = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_capacity_zero_rejects();
        test_first_values();
        test_random_insertions();
        test_back_pressure();
        test_wide_capacity();
        test_rejects_when_full();

        wait_for_results();
        repeat (MAX_ENTRIES + 16) @(negedge i_clk);
        if (expected_reports.size() != 0) begin
            $display("%0d expected results never arrived", expected_reports.size());
            error_count += expected_reports.size();
        end
        $display("Sent %0d values (%0d stored, %0d rejected), checked %0d results in %0d cycles.",
                 items_sent, items_stored, items_sent - items_stored, results_seen, cycle_count);
        $display("Capacities 0 to 2047, store filled to %0d, idle/stall/back-pressure phases.",
                 sorted_keys.size());
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
